// ===== design/pfst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sieve-table prime factorizer.
package pfst_pkg;

	localparam int FW             = 12;
	localparam int MAX_DEPTH      = 2 ** FW;
	localparam int TABLE_SIZE_DEF = 4096;

	typedef enum logic [3:0] {
		S_FILL,
		S_PRIME_RD,
		S_PRIME_CHK,
		S_MARK_RD,
		S_MARK_CHK,
		S_IDLE,
		S_LOOK_RD,
		S_LOOK_WAIT,
		S_DIV
	} state_t;

	typedef struct packed {
		logic fill;
		logic rd_sp;
		logic sp_inc;
		logic j_load;
		logic rd_j;
		logic mark;
		logic load_num;
		logic rd_rem;
		logic div_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic sq_lt;
		logic sp_prime;
		logic j_end;
		logic num_ok;
		logic div_done;
		logic quo_one;
	} status_t;

endpackage

// ===== design/pfst_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pfst_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/pfst_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module pfst_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [pfst_pkg::FW-1:0] dividend,
	input  logic [pfst_pkg::FW-1:0] divisor,
	output logic                   done,
	output logic [pfst_pkg::FW-1:0] quotient
);
	import pfst_pkg::*;

	localparam int CW = $clog2(FW);

	logic [FW-1:0] acc_q;
	logic [FW-1:0] quo_q;
	logic [FW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [FW:0]   shifted;
	logic [FW+1:0] diff;

	assign shifted = {acc_q, quo_q[FW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(FW - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(FW - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[FW+1]) begin
				acc_q <= diff[FW-1:0];
				quo_q <= {quo_q[FW-2:0], 1'b1};
			end else begin
				acc_q <= shifted[FW-1:0];
				quo_q <= {quo_q[FW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/pfst_dp.sv =====
`timescale 1ns / 1ps
// Datapath: factor table, sieve counters, working value and divider.
module pfst_dp #(
	parameter int TABLE_SIZE = pfst_pkg::TABLE_SIZE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pfst_pkg::cmd_t          cmd,
	output pfst_pkg::status_t       st,
	input  logic [pfst_pkg::FW-1:0] number,
	output logic                    valid,
	output logic [pfst_pkg::FW-1:0] prime_factor,
	output logic                    last
);
	import pfst_pkg::*;

	localparam int DEPTH = (TABLE_SIZE < MAX_DEPTH) ? TABLE_SIZE : MAX_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	logic [AW:0]     idx_q;
	logic [AW-1:0]   sp_q;
	logic [FW-1:0]   rem_q;
	logic [FW-1:0]   p_q;
	logic            valid_q;
	logic [FW-1:0]   factor_q;
	logic            last_q;

	logic [2*AW-1:0] sq;
	logic [FW-1:0]   rdata;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [FW-1:0]   wdata;
	logic [AW-1:0]   raddr;
	logic [FW-1:0]   fill_val;
	logic [FW-1:0]   p_sel;
	logic            div_done;
	logic [FW-1:0]   quo;

	assign sq       = sp_q * sp_q;
	assign fill_val = (idx_q >= (AW+1)'(4) && !idx_q[0]) ? FW'(2) : FW'(idx_q);

	assign we    = cmd.fill || (cmd.mark && rdata == FW'(idx_q));
	assign waddr = AW'(idx_q);
	assign wdata = cmd.fill ? fill_val : FW'(sp_q);

	always_comb begin
		if (cmd.rd_sp) begin
			raddr = sp_q;
		end else if (cmd.rd_j) begin
			raddr = AW'(idx_q);
		end else begin
			raddr = AW'(rem_q);
		end
	end

	assign p_sel = (rdata < FW'(2)) ? rem_q : rdata;

	pfst_ram #(
		.WIDTH(FW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	pfst_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(rem_q),
		.divisor (p_sel),
		.done    (div_done),
		.quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sp_q    <= AW'(3);
			valid_q <= 1'b0;
			rem_q   <= '0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.fill) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.j_load) begin
				idx_q <= (AW+1)'(sq);
			end else if (cmd.mark) begin
				idx_q <= idx_q + (AW+1)'(sp_q);
			end
			if (cmd.sp_inc) begin
				sp_q <= sp_q + 1'b1;
			end
			if (cmd.load_num) begin
				rem_q <= number;
			end else if (cmd.emit) begin
				rem_q <= quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			p_q <= p_sel;
		end
		if (cmd.emit) begin
			factor_q <= p_q;
			last_q   <= (quo < FW'(2));
		end
	end

	assign st.fill_last = (idx_q == (AW+1)'(DEPTH - 1));
	assign st.sq_lt     = (sq < (2*AW)'(DEPTH));
	assign st.sp_prime  = (rdata == FW'(sp_q));
	assign st.j_end     = (idx_q >= (AW+1)'(DEPTH));
	assign st.num_ok    = (number >= FW'(2)) && (32'(number) < 32'(TABLE_SIZE));
	assign st.div_done  = div_done;
	assign st.quo_one   = (quo < FW'(2));

	assign valid        = valid_q;
	assign prime_factor = factor_q;
	assign last         = last_q;

endmodule

// ===== design/pfst_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sieve sequencing after reset, then lookup and divide per factor.
module pfst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pfst_pkg::status_t st,
	output pfst_pkg::cmd_t    cmd,
	output logic              busy
);
	import pfst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_FILL: begin
				if (st.fill_last) state_d = S_PRIME_RD;
			end
			S_PRIME_RD: begin
				state_d = st.sq_lt ? S_PRIME_CHK : S_IDLE;
			end
			S_PRIME_CHK: begin
				state_d = st.sp_prime ? S_MARK_RD : S_PRIME_RD;
			end
			S_MARK_RD: begin
				state_d = st.j_end ? S_PRIME_RD : S_MARK_CHK;
			end
			S_MARK_CHK: begin
				state_d = S_MARK_RD;
			end
			S_IDLE: begin
				if (start && st.num_ok) state_d = S_LOOK_RD;
			end
			S_LOOK_RD: begin
				state_d = S_LOOK_WAIT;
			end
			S_LOOK_WAIT: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (st.div_done) state_d = st.quo_one ? S_IDLE : S_LOOK_RD;
			end
			default: state_d = S_FILL;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_FILL: begin
				cmd.fill = 1'b1;
			end
			S_PRIME_RD: begin
				cmd.rd_sp = st.sq_lt;
			end
			S_PRIME_CHK: begin
				cmd.j_load = st.sp_prime;
				cmd.sp_inc = !st.sp_prime;
			end
			S_MARK_RD: begin
				cmd.rd_j   = !st.j_end;
				cmd.sp_inc = st.j_end;
			end
			S_MARK_CHK: begin
				cmd.mark = 1'b1;
			end
			S_IDLE: begin
				busy         = 1'b0;
				cmd.load_num = start && st.num_ok;
			end
			S_LOOK_RD: begin
				cmd.rd_rem = 1'b1;
			end
			S_LOOK_WAIT: begin
				cmd.div_start = 1'b1;
			end
			S_DIV: begin
				cmd.emit = st.div_done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== design/prime_factor_by_sieve_table.sv =====
`timescale 1ns / 1ps
// Top level: prime factorizer using a smallest-prime-factor sieve table.
// After reset the sieve fills the table; busy stays high until it completes
// (it fills min(TABLE_SIZE,4096) entries, then marks each multiple in a read and a check state).
// Each factor takes a table read, then the divider, then an emit.
// One item is handled at a time.
// Results are strobed by valid for one cycle; the receiver cannot stall.
module prime_factor_by_sieve_table #(
	parameter int TABLE_SIZE = pfst_pkg::TABLE_SIZE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [pfst_pkg::FW-1:0] number,
	output logic                    valid,
	output logic [pfst_pkg::FW-1:0] prime_factor,
	output logic                    last
);
	import pfst_pkg::*;

	cmd_t    cmd;
	status_t st;

	pfst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.cmd   (cmd),
		.busy  (busy)
	);

	pfst_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.number      (number),
		.valid       (valid),
		.prime_factor(prime_factor),
		.last        (last)
	);

endmodule
